// ===== rtl/lttb_pkg.sv =====
`timescale 1ns / 1ps

package lttb_pkg;

    // buffer size and the write index range that follows from it
    localparam int OUT_BUFFER_BYTES = 65536;
    localparam int CAPACITY = (OUT_BUFFER_BYTES < 65536) ? OUT_BUFFER_BYTES : 65536;
    localparam int IDX_W = 17;
    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2**17
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int DIV3_SHIFT = 17;

    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [1:0] KIND_P = 2'd0;
    localparam logic [1:0] KIND_X = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam int TOK_COUNT = 6;
    localparam int TOK_MAX = 9;
    localparam logic [2:0] TOK_DATA = 3'd1;
    localparam logic [2:0] TOK_END = 3'd5;

    localparam logic [7:0] TOK_TEXT [TOK_COUNT][TOK_MAX] = '{
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "A", "T", "A", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"B", "L", "O", "C", "K", "D", "A", "T", "A"},
        '{"S", "Y", "M", "B", "O", "L", 8'h00, 8'h00, 8'h00},
        '{"C", "O", "M", "M", "E", "N", "T", 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] TOK_LEN [TOK_COUNT] = '{4'd5, 4'd4, 4'd9, 4'd6, 4'd7, 4'd3};

    typedef enum logic [12:0] {
        PH_SEEK_LINE   = 13'b0000000000001,
        PH_SEEK_TO_CR  = 13'b0000000000010,
        PH_SEEK_SKIP   = 13'b0000000000100,
        PH_TOKEN       = 13'b0000000001000,
        PH_KIND        = 13'b0000000010000,
        PH_GAP         = 13'b0000000100000,
        PH_ADDR        = 13'b0000001000000,
        PH_DATA_TO_CR  = 13'b0000010000000,
        PH_DATA_SKIP   = 13'b0000100000000,
        PH_DATA_LINE   = 13'b0001000000000,
        PH_DATA_INLINE = 13'b0010000000000,
        PH_WORD        = 13'b0100000000000,
        PH_DONE        = 13'b1000000000000
    } phase_t;

    // one accepted byte turns into at most one run of three sequential writes and one size back-patch,
    // or an empty finishing result
    typedef struct packed {
        logic                  has_a;
        logic [IDX_W-1:0]      base_idx;
        logic [2:0][7:0]       a_bytes;
        logic                  has_b;
        logic [IDX_W-1:0]      slot_idx;
        logic [15:0]           word_count;
        logic                  fin;
        logic [IDX_W-1:0]      end_idx;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - 8'h30;
        end
        if (c >= "A" && c <= "F") begin
            return c - 8'h37;
        end
        return c - 8'h57;
    endfunction

endpackage

// ===== rtl/lod_text_to_binary_converter.sv =====
`timescale 1ns / 1ps
// load file bytes are accepted one per cycle while the four-entry command queue has room
// the first write caused by a byte passes through the command queue and then the output register
// the output register sends one write per cycle while m_tready is high; a byte causes at most six
// writes, and six hex digits per word keep the average below one write per byte
// reset clears the parser state, the write index, the queue and the output valid
module lod_text_to_binary_converter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lttb_pkg::IN_TDATA_W-1:0]    s_tdata,   // byte_value
    input  logic                               s_tuser,   // first_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lttb_pkg::OUT_TDATA_W-1:0]   m_tdata,   // write_address, write_data, total_words, pad
    output logic [lttb_pkg::OUT_TUSER_W-1:0]   m_tuser,   // write_valid, overflow, finished
    output logic                               m_tlast    // last_result
);
    import lttb_pkg::*;

    logic           push;
    logic           pop;
    cmd_t           push_cmd;
    cmd_t           head_cmd;
    queue_status_t  status;

    assign s_tready = !status.full;

    lttb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .byte_value (s_tdata),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .push       (push),
        .cmd        (push_cmd)
    );

    lttb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    lttb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (!status.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/lttb_front.sv =====
`timescale 1ns / 1ps

module lttb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       byte_value,
    input  logic                             first_byte,
    input  logic                             last_byte,
    output logic                             push,
    output lttb_pkg::cmd_t                   cmd
);
    import lttb_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [3:0]        pos_reg, pos_next;
    logic [5:0]        cand_reg, cand_next;
    logic [2:0]        hc_reg, hc_next;
    logic [23:0]       pv_reg, pv_next;
    logic [IDX_W-1:0]  oi_reg, oi_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [15:0]       cnt_reg, cnt_next;

    phase_t            cur_phase;
    logic [3:0]        cur_pos;
    logic [5:0]        cur_cand;
    logic [2:0]        cur_hc;
    logic [23:0]       cur_pv;
    logic [IDX_W-1:0]  cur_oi;
    logic [IDX_W-1:0]  cur_slot;
    logic [15:0]       cur_cnt;

    logic [7:0]        d;
    logic [2:0]        wd_hc;
    logic [2:0]        wd_hc1;
    logic [23:0]       wd_pv;
    logic [15:0]       ad_pv;
    logic [2:0]        ad_hc1;
    logic [IDX_W-1:0]  oi_sum3;
    logic [IDX_W-1:0]  oi_plus3;
    logic [IDX_W-1:0]  oi_sum6;
    logic [IDX_W-1:0]  oi_plus6;
    logic [5:0]        keep;
    logic              found;
    logic [2:0]        tok_idx;
    logic              do_word;
    logic              has_a;
    logic [2:0][7:0]   a_bytes;
    logic              has_b;
    logic              fin;
    logic              accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        cur_phase = first_byte ? PH_SEEK_LINE : phase_reg;
        cur_pos   = first_byte ? 4'd0 : pos_reg;
        cur_cand  = first_byte ? 6'h3f : cand_reg;
        cur_hc    = first_byte ? 3'd0 : hc_reg;
        cur_pv    = first_byte ? 24'd0 : pv_reg;
        cur_oi    = first_byte ? '0 : oi_reg;
        cur_slot  = first_byte ? '0 : slot_reg;
        cur_cnt   = first_byte ? 16'd0 : cnt_reg;
    end

    always_comb
    begin
        d = hex_value(byte_value);

        // word digits pair into bytes; a fresh run starts its count at zero
        wd_hc = (cur_phase == PH_WORD) ? cur_hc : 3'd0;
        if (wd_hc[0])
        begin
            wd_pv = {cur_pv[23:8], {cur_pv[3:0], 4'h0} + d};
        end
        else
        begin
            wd_pv = {cur_pv[15:0], d};
        end
        wd_hc1 = wd_hc + 3'd1;

        ad_pv  = {cur_pv[11:0], 4'h0} + {8'h00, d};
        ad_hc1 = cur_hc + 3'd1;

        // index saturates at the buffer size
        oi_sum3  = cur_oi + IDX_W'(3);
        oi_plus3 = (oi_sum3 > CAP_IDX) ? CAP_IDX : oi_sum3;
        oi_sum6  = oi_plus3 + IDX_W'(3);
        oi_plus6 = (oi_sum6 > CAP_IDX) ? CAP_IDX : oi_sum6;

        keep = '0;
        for (int i = 0; i < TOK_COUNT; i++)
        begin
            if (cur_cand[i] && cur_pos < TOK_LEN[i])
            begin
                if (byte_value == TOK_TEXT[i][cur_pos[3:0]]
                    || byte_value == TOK_TEXT[i][cur_pos[3:0]] + CASE_OFFSET)
                begin
                    keep[i] = 1'b1;
                end
            end
        end
        found   = 1'b0;
        tok_idx = 3'd0;
        for (int i = 0; i < TOK_COUNT; i++)
        begin
            if (!found && keep[i] && TOK_LEN[i] == cur_pos + 4'd1)
            begin
                found   = 1'b1;
                tok_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        phase_next = cur_phase;
        pos_next   = cur_pos;
        cand_next  = cur_cand;
        hc_next    = cur_hc;
        pv_next    = cur_pv;
        oi_next    = cur_oi;
        slot_next  = cur_slot;
        cnt_next   = cur_cnt;
        do_word    = 1'b0;
        has_a      = 1'b0;
        a_bytes    = '0;
        has_b      = 1'b0;
        fin        = 1'b0;

        unique case (cur_phase)
            PH_SEEK_LINE:
            begin
                if (byte_value == CH_UNDERSCORE)
                begin
                    phase_next = PH_TOKEN;
                    pos_next   = 4'd0;
                    cand_next  = 6'h3f;
                end
                else
                begin
                    phase_next = (byte_value == CH_CR) ? PH_SEEK_SKIP : PH_SEEK_TO_CR;
                end
            end
            PH_SEEK_TO_CR:
            begin
                phase_next = (byte_value == CH_CR) ? PH_SEEK_SKIP : PH_SEEK_TO_CR;
            end
            PH_SEEK_SKIP:
            begin
                phase_next = PH_SEEK_LINE;
            end
            PH_TOKEN:
            begin
                cand_next = keep;
                if (keep == '0)
                begin
                    phase_next = (byte_value == CH_CR) ? PH_SEEK_SKIP : PH_SEEK_TO_CR;
                end
                else if (found)
                begin
                    if (tok_idx == TOK_DATA)
                    begin
                        phase_next = PH_KIND;
                    end
                    else if (tok_idx == TOK_END)
                    begin
                        phase_next = PH_DONE;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SEEK_TO_CR;
                    end
                end
                else
                begin
                    pos_next = cur_pos + 4'd1;
                end
            end
            PH_KIND:
            begin
                if (byte_value != CH_SPACE)
                begin
                    has_a      = 1'b1;
                    a_bytes[2] = (byte_value == CH_P) ? {6'd0, KIND_P}
                               : (byte_value == CH_X) ? {6'd0, KIND_X}
                               : {6'd0, KIND_OTHER};
                    oi_next    = oi_plus3;
                    phase_next = PH_GAP;
                end
            end
            PH_GAP:
            begin
                hc_next    = 3'd0;
                pv_next    = 24'd0;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                pv_next = {8'h00, ad_pv};
                hc_next = ad_hc1;
                if (ad_hc1 >= 3'd4)
                begin
                    has_a      = 1'b1;
                    a_bytes[1] = ad_pv[15:8];
                    a_bytes[2] = ad_pv[7:0];
                    cnt_next   = 16'd0;
                    slot_next  = oi_plus3;
                    oi_next    = oi_plus6;
                    hc_next    = 3'd0;
                    pv_next    = 24'd0;
                    phase_next = PH_DATA_TO_CR;
                end
            end
            PH_DATA_TO_CR:
            begin
                if (byte_value == CH_CR)
                begin
                    phase_next = PH_DATA_SKIP;
                end
            end
            PH_DATA_SKIP:
            begin
                phase_next = PH_DATA_LINE;
            end
            PH_DATA_LINE:
            begin
                if (byte_value == CH_UNDERSCORE)
                begin
                    has_b      = 1'b1;
                    phase_next = PH_TOKEN;
                    pos_next   = 4'd0;
                    cand_next  = 6'h3f;
                end
                else if (byte_value == CH_CR)
                begin
                    phase_next = PH_DATA_SKIP;
                end
                else if (byte_value == CH_SPACE)
                begin
                    phase_next = PH_DATA_INLINE;
                end
                else
                begin
                    do_word = 1'b1;
                end
            end
            PH_DATA_INLINE:
            begin
                if (byte_value == CH_CR)
                begin
                    phase_next = PH_DATA_SKIP;
                end
                else if (byte_value != CH_SPACE)
                begin
                    do_word = 1'b1;
                end
            end
            PH_WORD:
            begin
                do_word = 1'b1;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (do_word)
        begin
            if (wd_hc1 >= 3'd6)
            begin
                has_a      = 1'b1;
                a_bytes[0] = wd_pv[23:16];
                a_bytes[1] = wd_pv[15:8];
                a_bytes[2] = wd_pv[7:0];
                oi_next    = oi_plus3;
                cnt_next   = cur_cnt + 16'd1;
                hc_next    = 3'd0;
                pv_next    = 24'd0;
                phase_next = PH_DATA_INLINE;
            end
            else
            begin
                hc_next    = wd_hc1;
                pv_next    = wd_pv;
                phase_next = PH_WORD;
            end
        end

        // end of buffer closes an open data block and finishes the parse
        if (last_byte && !fin && cur_phase != PH_DONE)
        begin
            if (phase_next == PH_DATA_TO_CR || phase_next == PH_DATA_SKIP
                || phase_next == PH_DATA_LINE || phase_next == PH_DATA_INLINE
                || phase_next == PH_WORD)
            begin
                has_b = 1'b1;
            end
            phase_next = PH_DONE;
            fin        = 1'b1;
        end
    end

    always_comb
    begin
        cmd.has_a      = has_a;
        cmd.base_idx   = cur_oi;
        cmd.a_bytes    = a_bytes;
        cmd.has_b      = has_b;
        cmd.slot_idx   = slot_next;
        cmd.word_count = cnt_next;
        cmd.fin        = fin;
        cmd.end_idx    = oi_next;
    end

    assign push = accept && (has_a || has_b || fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK_LINE;
            pos_reg   <= 4'd0;
            cand_reg  <= 6'h3f;
            hc_reg    <= 3'd0;
            pv_reg    <= 24'd0;
            oi_reg    <= '0;
            slot_reg  <= '0;
            cnt_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            hc_reg    <= hc_next;
            pv_reg    <= pv_next;
            oi_reg    <= oi_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/lttb_queue.sv =====
`timescale 1ns / 1ps

module lttb_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lttb_pkg::cmd_t            push_cmd,
    input  logic                      pop,
    output lttb_pkg::cmd_t            head_cmd,
    output lttb_pkg::queue_status_t   status
);
    import lttb_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/lttb_back.sv =====
`timescale 1ns / 1ps

module lttb_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lttb_pkg::cmd_t                     head_cmd,
    input  logic                               head_valid,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lttb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [lttb_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                               m_tlast
);
    import lttb_pkg::*;

    logic                    valid_reg;
    logic [OUT_TDATA_W-1:0]  tdata_reg;
    logic [OUT_TUSER_W-1:0]  tuser_reg;
    logic                    tlast_reg;
    logic [2:0]              sub_reg, sub_next;

    logic                    load;
    logic                    empty_cmd;
    logic [2:0]              eff;
    logic                    res_last;
    logic [IDX_W-1:0]        idx;
    logic [7:0]              wr_data;
    logic                    wr_valid;
    logic                    wr_ovf;
    logic [15:0]             wr_addr;
    logic [IDX_W+15:0]       prod;
    logic [14:0]             total;

    assign load = head_valid && (!valid_reg || m_tready);

    always_comb
    begin
        empty_cmd = !head_cmd.has_a && !head_cmd.has_b;
        // writes run through the sequential group, then the back-patch
        eff      = head_cmd.has_a ? sub_reg : sub_reg + 3'd3;
        res_last = empty_cmd || eff == 3'd5 || (eff == 3'd2 && !head_cmd.has_b);

        idx     = '0;
        wr_data = 8'h00;
        case (eff)
            3'd0:
            begin
                idx     = head_cmd.base_idx;
                wr_data = head_cmd.a_bytes[0];
            end
            3'd1:
            begin
                idx     = head_cmd.base_idx + IDX_W'(1);
                wr_data = head_cmd.a_bytes[1];
            end
            3'd2:
            begin
                idx     = head_cmd.base_idx + IDX_W'(2);
                wr_data = head_cmd.a_bytes[2];
            end
            3'd3:
            begin
                idx     = head_cmd.slot_idx;
                wr_data = 8'h00;
            end
            3'd4:
            begin
                idx     = head_cmd.slot_idx + IDX_W'(1);
                wr_data = head_cmd.word_count[15:8];
            end
            3'd5:
            begin
                idx     = head_cmd.slot_idx + IDX_W'(2);
                wr_data = head_cmd.word_count[7:0];
            end
            default:
            begin
                idx     = '0;
                wr_data = 8'h00;
            end
        endcase

        wr_valid = !empty_cmd && (idx < CAP_IDX);
        wr_ovf   = !empty_cmd && !(idx < CAP_IDX);
        wr_addr  = wr_valid ? idx[15:0] : 16'd0;
        if (!wr_valid)
        begin
            wr_data = 8'h00;
        end

        prod  = head_cmd.end_idx * DIV3_RECIP;
        total = prod[DIV3_SHIFT+14:DIV3_SHIFT];

        sub_next = sub_reg;
        pop      = 1'b0;
        if (load)
        begin
            if (res_last)
            begin
                sub_next = 3'd0;
                pop      = 1'b1;
            end
            else
            begin
                sub_next = sub_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 3'd0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= {1'b0, total, wr_data, wr_addr};
            tuser_reg <= {head_cmd.fin, wr_ovf, wr_valid};
            tlast_reg <= res_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lttb_pkg::*;

    typedef struct packed {
        logic        wr_valid;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        ovf;
        logic        fin;
        logic [14:0] words;
        logic        last_wr;
    } write_result_t;

    localparam int unsigned CAP = CAPACITY;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    lod_text_to_binary_converter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    int errors = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_left = 0;

    write_result_t expected_writes[$];
    write_result_t step_writes[$];
    logic [7:0]    file_q[$];

    // parser state mirrored by the predictor
    phase_t      ph = PH_SEEK_LINE;
    logic [3:0]  tok_pos;
    logic [5:0]  tok_cand;
    logic [2:0]  digit_cnt;
    logic [23:0] acc;
    logic [1:0]  mem_kind;
    int unsigned out_idx;
    int unsigned slot_idx;
    logic [15:0] word_cnt;

    string tok_names [6] = '{"START", "DATA", "BLOCKDATA", "SYMBOL", "COMMENT", "END"};

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 20)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    function automatic void parser_reset();
        ph = PH_SEEK_LINE;
        tok_pos = '0;
        tok_cand = 6'h3f;
        digit_cnt = '0;
        acc = '0;
        mem_kind = KIND_P;
        out_idx = 0;
        slot_idx = 0;
        word_cnt = '0;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - 8'd48;
        end
        if (c >= "A" && c <= "F")
        begin
            return c - 8'd55;
        end
        // anything else decodes as a lowercase digit, wrapping at 8 bits
        return c - 8'd87;
    endfunction

    function automatic void put_at(input int unsigned idx, input logic [7:0] d);
        write_result_t w;
        w = '0;
        if (step_writes.size() >= 6)
        begin
            return;
        end
        if (idx < CAP)
        begin
            w.wr_valid = 1'b1;
            w.addr = idx[15:0];
            w.data = d;
        end
        else
        begin
            w.ovf = 1'b1;
        end
        step_writes.push_back(w);
    endfunction

    function automatic void put_next(input logic [7:0] d);
        put_at(out_idx, d);
        if (out_idx < CAP)
        begin
            out_idx++;
        end
    endfunction

    function automatic void size_patch();
        put_at(slot_idx, 8'd0);
        put_at(slot_idx + 1, word_cnt[15:8]);
        put_at(slot_idx + 2, word_cnt[7:0]);
    endfunction

    function automatic void skip_char(input logic [7:0] c);
        ph = (c == CH_CR) ? PH_SEEK_SKIP : PH_SEEK_TO_CR;
    endfunction

    function automatic void start_token();
        ph = PH_TOKEN;
        tok_pos = '0;
        tok_cand = 6'h3f;
    endfunction

    function automatic void word_digit(input logic [7:0] c);
        logic [7:0] d;
        d = digit_value(c);
        if (!digit_cnt[0])
        begin
            acc = {acc[15:0], d};
        end
        else
        begin
            acc[7:0] = {acc[3:0], 4'd0} + d;
        end
        digit_cnt++;
        if (digit_cnt >= 3'd6)
        begin
            put_next(acc[23:16]);
            put_next(acc[15:8]);
            put_next(acc[7:0]);
            word_cnt++;
            digit_cnt = '0;
            acc = '0;
            ph = PH_DATA_INLINE;
        end
        else
        begin
            ph = PH_WORD;
        end
    endfunction

    function automatic void data_char(input logic [7:0] c);
        if (c == CH_CR)
        begin
            ph = PH_DATA_SKIP;
        end
        else if (c == CH_SPACE)
        begin
            ph = PH_DATA_INLINE;
        end
        else
        begin
            digit_cnt = '0;
            word_digit(c);
        end
    endfunction

    // returns 1 when the end token completes
    function automatic logic token_char(input logic [7:0] c);
        logic [5:0] keep;
        logic [7:0] t;
        keep = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (tok_cand[i] && tok_pos < tok_names[i].len())
            begin
                t = tok_names[i][tok_pos];
                if (c == t || c == t + CASE_OFFSET)
                begin
                    keep[i] = 1'b1;
                end
            end
        end
        tok_cand = keep;
        if (keep == '0)
        begin
            skip_char(c);
            return 1'b0;
        end
        for (int i = 0; i < 6; i++)
        begin
            if (keep[i] && tok_names[i].len() == tok_pos + 1)
            begin
                if (i == TOK_DATA)
                begin
                    ph = PH_KIND;
                end
                else if (i == TOK_END)
                begin
                    ph = PH_DONE;
                    return 1'b1;
                end
                else
                begin
                    ph = PH_SEEK_TO_CR;
                end
                return 1'b0;
            end
        end
        tok_pos++;
        return 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] c, input logic first, input logic last);
        logic          fin;
        write_result_t w;
        fin = 1'b0;
        step_writes.delete();
        if (first)
        begin
            parser_reset();
        end
        case (ph)
            PH_SEEK_LINE:
            begin
                if (c == CH_UNDERSCORE)
                begin
                    start_token();
                end
                else
                begin
                    skip_char(c);
                end
            end
            PH_SEEK_TO_CR: skip_char(c);
            PH_SEEK_SKIP: ph = PH_SEEK_LINE;
            PH_TOKEN: fin = token_char(c);
            PH_KIND:
            begin
                if (c != CH_SPACE)
                begin
                    mem_kind = (c == CH_P) ? KIND_P : (c == CH_X) ? KIND_X : KIND_OTHER;
                    put_next(8'd0);
                    put_next(8'd0);
                    put_next({6'd0, mem_kind});
                    ph = PH_GAP;
                end
            end
            PH_GAP:
            begin
                digit_cnt = '0;
                acc = '0;
                ph = PH_ADDR;
            end
            PH_ADDR:
            begin
                acc = {8'd0, {acc[11:0], 4'd0} + 16'(digit_value(c))};
                digit_cnt++;
                if (digit_cnt >= 3'd4)
                begin
                    put_next(8'd0);
                    put_next(acc[15:8]);
                    put_next(acc[7:0]);
                    word_cnt = '0;
                    slot_idx = out_idx;
                    // the size slot is reserved now and patched when the section ends
                    out_idx = (out_idx + 3 > CAP) ? CAP : out_idx + 3;
                    digit_cnt = '0;
                    acc = '0;
                    ph = PH_DATA_TO_CR;
                end
            end
            PH_DATA_TO_CR:
            begin
                if (c == CH_CR)
                begin
                    ph = PH_DATA_SKIP;
                end
            end
            PH_DATA_SKIP: ph = PH_DATA_LINE;
            PH_DATA_LINE:
            begin
                if (c == CH_UNDERSCORE)
                begin
                    size_patch();
                    start_token();
                end
                else
                begin
                    data_char(c);
                end
            end
            PH_DATA_INLINE: data_char(c);
            PH_WORD: word_digit(c);
            default:
            begin
                ph = PH_DONE;
                return;
            end
        endcase

        if (last && !fin)
        begin
            if (ph == PH_DATA_TO_CR || ph == PH_DATA_SKIP || ph == PH_DATA_LINE ||
                ph == PH_DATA_INLINE || ph == PH_WORD)
            begin
                size_patch();
            end
            ph = PH_DONE;
            fin = 1'b1;
        end

        if (step_writes.size() == 0 && fin)
        begin
            w = '0;
            step_writes.push_back(w);
        end
        for (int k = 0; k < step_writes.size(); k++)
        begin
            w = step_writes[k];
            w.fin = fin;
            w.words = 15'(out_idx / 3);
            w.last_wr = (k == step_writes.size() - 1);
            expected_writes.push_back(w);
        end
    endtask

    // write results are checked in order as they leave the block
    write_result_t got_w;
    write_result_t exp_w;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_w.wr_valid = m_tuser[0];
            got_w.ovf = m_tuser[1];
            got_w.fin = m_tuser[2];
            got_w.addr = m_tdata[15:0];
            got_w.data = m_tdata[23:16];
            got_w.words = m_tdata[38:24];
            got_w.last_wr = m_tlast;
            if (expected_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected write addr %04h data %02h",
                                          got_w.addr, got_w.data));
            end
            else
            begin
                exp_w = expected_writes.pop_front();
                if (got_w !== exp_w)
                begin
                    report_mismatch($sformatf(
                        "got v%0b a%04h d%02h o%0b f%0b w%0d l%0b, exp v%0b a%04h d%02h o%0b f%0b w%0d l%0b",
                        got_w.wr_valid, got_w.addr, got_w.data, got_w.ovf, got_w.fin,
                        got_w.words, got_w.last_wr, exp_w.wr_valid, exp_w.addr, exp_w.data,
                        exp_w.ovf, exp_w.fin, exp_w.words, exp_w.last_wr));
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic first, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= first;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        parse_byte(c, first, last);
    endtask

    task automatic send_text(input string s, input logic first, input logic last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], first && i == 0, last && i == s.len() - 1);
        end
    endtask

    task automatic send_file(input logic last);
        for (int i = 0; i < file_q.size(); i++)
        begin
            send_byte(file_q[i], i == 0, last && i == file_q.size() - 1);
        end
    endtask

    // random bytes with restarts and end marks anywhere
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom_range(255)), i == 0 || $urandom_range(15) == 0,
                      $urandom_range(15) == 0);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z" && $urandom_range(1) == 1)
        begin
            return ch + CASE_OFFSET;
        end
        return ch;
    endfunction

    function automatic logic [7:0] rand_digit();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        if ($urandom_range(19) == 0)
        begin
            return 8'($urandom_range(255));
        end
        return digits[$urandom_range(21)];
    endfunction

    function automatic void push_token(input string s);
        file_q.push_back(CH_UNDERSCORE);
        for (int i = 0; i < s.len(); i++)
        begin
            file_q.push_back(mixed_case(s[i]));
        end
    endfunction

    function automatic void push_line_end();
        file_q.push_back(CH_CR);
        file_q.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h0a);
    endfunction

    // builds a small load file; returns 1 when it ends by the end mark rather than END
    function automatic logic build_file();
        string      other_names [5];
        string      s;
        logic [7:0] kind_ch;
        int         n_digits;
        other_names = '{"START", "BLOCKDATA", "SYMBOL", "COMMENT", "QUIT"};
        file_q.delete();
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(255)));
            push_line_end();
        end
        if ($urandom_range(9) < 7)
        begin
            push_token("DATA");
            repeat ($urandom_range(2)) file_q.push_back(CH_SPACE);
            case ($urandom_range(4))
                0: kind_ch = CH_P;
                1: kind_ch = CH_X;
                2: kind_ch = "p";
                3: kind_ch = "Y";
                default: kind_ch = 8'($urandom_range(255));
            endcase
            file_q.push_back(kind_ch);
            file_q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : CH_SPACE);
            repeat (4) file_q.push_back(rand_digit());
            repeat ($urandom_range(2)) file_q.push_back(8'($urandom_range(33, 126)));
            push_line_end();
            repeat ($urandom_range(1, 2))
            begin
                n_digits = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 6;
                repeat (n_digits) file_q.push_back(rand_digit());
                repeat ($urandom_range(1, 2)) file_q.push_back(CH_SPACE);
            end
            push_line_end();
        end
        else
        begin
            s = other_names[$urandom_range(4)];
            s = s.substr(0, $urandom_range(s.len() - 1));
            push_token(s);
            repeat ($urandom_range(3)) file_q.push_back(8'($urandom_range(33, 126)));
            push_line_end();
        end
        if ($urandom_range(1) == 0)
        begin
            push_token("END");
            if ($urandom_range(1) == 0)
            begin
                file_q.push_back(8'($urandom_range(255)));
            end
            return 1'b0;
        end
        // cut the tail so the file may end inside a word
        repeat ($urandom_range(4)) void'(file_q.pop_back());
        return 1'b1;
    endfunction

    task automatic run_traffic_phase(input int src_pct, input int snk_pct, input int n_bytes);
        int   sent;
        logic by_mark;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_noise(8);
                sent += 8;
            end
            else
            begin
                by_mark = build_file();
                send_file(by_mark);
                sent += file_q.size();
            end
        end
        wait_drained();
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // mixed-case data section, one word, then END; later bytes are ignored
        send_text("_dAtA X 12ab\015\01200FF7f\015\012_EnD", 1'b1, 1'b0);
        send_byte("Q", 1'b0, 1'b1);
        // partial and unknown tokens, other kind, CR taken as an address digit,
        // file ending inside a word so the size is patched on the last byte
        send_text("_sy\015\012_q\015\012_DATAp 0\0153g\015\012", 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // single-byte file
        send_byte(CH_UNDERSCORE, 1'b1, 1'b1);
        // restart inside a data section
        send_text("_DATAX 0000\015\01211", 1'b1, 1'b0);
        send_text("_end", 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 8);
        run_traffic_phase(72, 0, 8);
        run_traffic_phase(0, 72, 8);
        run_traffic_phase(17, 17, 8);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_left = 200;
        send_text("_DATAX 0100\015\012112233 445566\015\012_END", 1'b1, 1'b0);
        wait_drained();
    endtask

    initial
    begin
        parser_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
